@@ rtl/core/scp_pkg.sv @@
package scp_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROT0     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT1     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT2     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_XY = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_XY  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_Z   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE    = 4'd7;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [47:0] ROT_ONE = 48'd16384;

  // clip fraction is Q.28, pixel quotient is 32 bits
  localparam int unsigned CLIP_QW = 28;
  localparam int unsigned CLIP_DW = 33;
  localparam int unsigned PIX_QW  = 32;
  localparam int unsigned PIX_DW  = 53;

  typedef struct packed {
    logic [47:0]        rot0;
    logic [47:0]        rot1;
    logic [47:0]        rot2;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [15:0] p00;
    logic signed [15:0] p02;
    logic signed [15:0] p11;
    logic signed [15:0] p12;
    logic signed [31:0] p22;
    logic signed [31:0] p23;
    logic [15:0]        img_w;
    logic [15:0]        img_h;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_t;

  typedef struct packed {
    pt_t  p0;
    pt_t  p1;
    logic below0;
    logic below1;
  } mid_t;

  typedef struct packed {
    pt_t  a_pt;
    pt_t  b_pt;
    logic cull;
    logic clipped;
    logic front_on_plane;
  } clip_pay_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] start_px;
    logic signed [15:0] start_py;
    logic signed [15:0] end_px;
    logic signed [15:0] end_py;
    logic               was_clipped;
  } res_t;

endpackage

@@ rtl/core/segment_clip_project.sv @@
// segment_clip_project: camera transform, near-plane clip and projection
// of one 3d line segment per item.
// input side is a queue write port: an item enters on an edge with push high
// and full low. result side is a queue read port: the oldest result sits on
// the result ports while empty is low and leaves on an edge with pop high.
// configuration uses cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; write only while no item is in flight.
// throughput is one item per cycle while full stays low. the pipeline depth is
// set mostly by the 28-step clip fraction divider and the
// 32-step pixel quotient dividers, each retiring one quotient bit per stage.
// a front pipeline (camera transform: input and product registers) feeds
// a small queue, and the back pipeline (clip, projection, divide, pixel
// scale) feeds the result queue; either half stalls without losing items.
// when pop stays low, the back half stops once the result queue fills,
// then the middle queue fills and full rises.
// reset empties both queues and all pipeline stages and loads the identity
// rotation with all other registers zero.
module segment_clip_project import scp_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   first_x,
  input  logic signed [31:0]   first_y,
  input  logic signed [31:0]   first_z,
  input  logic signed [31:0]   second_x,
  input  logic signed [31:0]   second_y,
  input  logic signed [31:0]   second_z,
  input  logic                 pop,
  output logic                 empty,
  output logic                 visible,
  output logic signed [15:0]   start_px,
  output logic signed [15:0]   start_py,
  output logic signed [15:0]   end_px,
  output logic signed [15:0]   end_py,
  output logic                 was_clipped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_t cfg;
  pt_t  in_p0;
  pt_t  in_p1;
  logic front_ready;
  logic mid_push;
  mid_t mid_din;
  logic mid_full;
  logic mid_pop;
  mid_t mid_dout;
  logic mid_empty;
  logic out_push;
  res_t out_din;
  logic out_full;
  res_t out_dout;

  assign cfg_ready = 1'b1;
  assign full      = !front_ready;

  always_comb begin
    in_p0.x = first_x;
    in_p0.y = first_y;
    in_p0.z = first_z;
    in_p1.x = second_x;
    in_p1.y = second_y;
    in_p1.z = second_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot0  <= ROT_ONE;
      cfg.rot1  <= ROT_ONE << 16;
      cfg.rot2  <= ROT_ONE << 32;
      cfg.tx    <= '0;
      cfg.ty    <= '0;
      cfg.tz    <= '0;
      cfg.p00   <= '0;
      cfg.p02   <= '0;
      cfg.p11   <= '0;
      cfg.p12   <= '0;
      cfg.p22   <= '0;
      cfg.p23   <= '0;
      cfg.img_w <= '0;
      cfg.img_h <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT0: begin
          cfg.rot0 <= cfg_data[47:0];
        end
        REG_ROT1: begin
          cfg.rot1 <= cfg_data[47:0];
        end
        REG_ROT2: begin
          cfg.rot2 <= cfg_data[47:0];
        end
        REG_TRANS_XY: begin
          cfg.tx <= cfg_data[31:0];
          cfg.ty <= cfg_data[63:32];
        end
        REG_TRANS_Z: begin
          cfg.tz <= cfg_data[31:0];
        end
        REG_PROJ_XY: begin
          cfg.p00 <= cfg_data[15:0];
          cfg.p02 <= cfg_data[31:16];
          cfg.p11 <= cfg_data[47:32];
          cfg.p12 <= cfg_data[63:48];
        end
        REG_PROJ_Z: begin
          cfg.p22 <= cfg_data[31:0];
          cfg.p23 <= cfg_data[63:32];
        end
        REG_IMAGE: begin
          cfg.img_w <= cfg_data[15:0];
          cfg.img_h <= cfg_data[31:16];
        end
        default: begin
        end
      endcase
    end
  end

  scp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(push),
    .in_p0   (in_p0),
    .in_p1   (in_p1),
    .in_ready(front_ready),
    .q_push  (mid_push),
    .q_data  (mid_din),
    .q_full  (mid_full)
  );

  scp_fifo #(
    .WIDTH($bits(mid_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .din  (mid_din),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  scp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (mid_empty),
    .q_data  (mid_dout),
    .q_pop   (mid_pop),
    .out_push(out_push),
    .out_data(out_din),
    .out_full(out_full)
  );

  scp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  (out_din),
    .full (out_full),
    .pop  (pop),
    .dout (out_dout),
    .empty(empty)
  );

  assign visible     = out_dout.visible;
  assign start_px    = out_dout.start_px;
  assign start_py    = out_dout.start_py;
  assign end_px      = out_dout.end_px;
  assign end_py      = out_dout.end_py;
  assign was_clipped = out_dout.was_clipped;

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not clear after reset");

  a_hidden_coords: assert property (@(posedge clk) disable iff (rst)
      (!empty && !visible) |->
      (start_px == -16'sd1 && start_py == -16'sd1 &&
       end_px == -16'sd1 && end_py == -16'sd1))
    else $error("hidden segment with coordinates other than -1");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule

@@ rtl/core/scp_fifo.sv @@
module scp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ rtl/core/scp_div.sv @@
module scp_div #(
  parameter int DW = 33,
  parameter int QW = 28,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_num,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] den [QW+1];
  logic [QW-1:0] num [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [PW-1:0] pay [QW+1];
  logic [QW:0]   valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= in_rem;
      den[0] <= in_den;
      num[0] <= in_num;
      quo[0] <= '0;
      pay[0] <= in_pay;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[s], num[s][QW-1]};
      diff  = trial - {1'b0, den[s]};
      ge    = (trial >= {1'b0, den[s]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (en) begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den[s+1] <= den[s];
        num[s+1] <= num[s] << 1;
        quo[s+1] <= {quo[s][QW-2:0], ge};
        pay[s+1] <= pay[s];
      end
    end
  end

  assign out_valid = valid[QW];
  assign out_quo   = quo[QW];
  assign out_pay   = pay[QW];

endmodule

@@ rtl/core/scp_front.sv @@
module scp_front import scp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  input  pt_t  in_p0,
  input  pt_t  in_p1,
  output logic in_ready,
  output logic q_push,
  output mid_t q_data,
  input  logic q_full
);

  logic               en;
  logic               f0_valid;
  logic               f1_valid;
  pt_t                f0_pt [2];
  logic signed [15:0] rot [3][3];
  logic signed [31:0] crd [2][3];
  logic signed [31:0] trans [3];
  logic signed [47:0] f1_prod [2][3][3];
  logic signed [31:0] cam [2][3];
  logic signed [49:0] acc;
  logic signed [35:0] shf;
  logic signed [36:0] sum;

  assign en       = !(f1_valid && q_full);
  assign in_ready = en;
  assign q_push   = f1_valid && !q_full;

  always_comb begin
    rot[0][0] = cfg.rot0[15:0];
    rot[0][1] = cfg.rot0[31:16];
    rot[0][2] = cfg.rot0[47:32];
    rot[1][0] = cfg.rot1[15:0];
    rot[1][1] = cfg.rot1[31:16];
    rot[1][2] = cfg.rot1[47:32];
    rot[2][0] = cfg.rot2[15:0];
    rot[2][1] = cfg.rot2[31:16];
    rot[2][2] = cfg.rot2[47:32];
    trans[0]  = cfg.tx;
    trans[1]  = cfg.ty;
    trans[2]  = cfg.tz;
    for (int k = 0; k < 2; k++) begin
      crd[k][0] = f0_pt[k].x;
      crd[k][1] = f0_pt[k].y;
      crd[k][2] = f0_pt[k].z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
    end else if (en) begin
      f0_valid <= in_valid;
      f1_valid <= f0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_pt[0] <= in_p0;
      f0_pt[1] <= in_p1;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            f1_prod[k][i][j] <= rot[i][j] * crd[k][j];
          end
        end
      end
    end
  end

  // floor shift, translate, saturate to q16.16
  always_comb begin
    acc = '0;
    shf = '0;
    sum = '0;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        acc = 50'(f1_prod[k][i][0]) + 50'(f1_prod[k][i][1]) + 50'(f1_prod[k][i][2]);
        shf = 36'(acc >>> 14);
        sum = 37'(shf) + 37'(trans[i]);
        if (sum > 37'sd2147483647) begin
          cam[k][i] = 32'sh7fff_ffff;
        end else if (sum < -37'sd2147483648) begin
          cam[k][i] = 32'sh8000_0000;
        end else begin
          cam[k][i] = sum[31:0];
        end
      end
    end
    q_data.p0.x   = cam[0][0];
    q_data.p0.y   = cam[0][1];
    q_data.p0.z   = cam[0][2];
    q_data.p1.x   = cam[1][0];
    q_data.p1.y   = cam[1][1];
    q_data.p1.z   = cam[1][2];
    q_data.below0 = cam[0][2] < ONE_Q16;
    q_data.below1 = cam[1][2] < ONE_Q16;
  end

endmodule

@@ rtl/core/scp_back.sv @@
module scp_back import scp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  mid_t q_data,
  output logic q_pop,
  output logic out_push,
  output res_t out_data,
  input  logic out_full
);

  logic back_en;

  // item taken from the queue
  logic               sa_valid;
  mid_t               sa_item;
  clip_pay_t          cd_pay_in;
  logic signed [32:0] clip_a;
  logic signed [32:0] clip_d;

  // clip fraction divider
  logic               cd_valid;
  logic [CLIP_QW-1:0] cd_t;
  clip_pay_t          cd_pay;

  // fraction times delta, split in halves
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [14:0] th;
  logic signed [14:0] tl;
  logic               sm_valid;
  logic signed [47:0] sm_dxh;
  logic signed [47:0] sm_dxl;
  logic signed [47:0] sm_dyh;
  logic signed [47:0] sm_dyl;
  clip_pay_t          sm_pay;

  // output points
  logic signed [61:0] fx_full;
  logic signed [61:0] fy_full;
  logic signed [61:0] fx_sum;
  logic signed [61:0] fy_sum;
  pt_t                sn_next0;
  logic               sn_valid;
  pt_t                sn_pt [2];
  logic               sn_cull;
  logic               sn_clipped;

  // projection products
  logic               sp_valid;
  logic signed [47:0] sp_mx [2];
  logic signed [47:0] sp_mxz [2];
  logic signed [47:0] sp_my [2];
  logic signed [47:0] sp_myz [2];
  logic signed [63:0] sp_mzz [2];
  logic               sp_cull;
  logic               sp_clipped;

  // clip coordinates
  logic signed [64:0] cz_sum [2];
  logic               sq_valid;
  logic signed [48:0] sq_cx [2];
  logic signed [48:0] sq_cy [2];
  logic signed [52:0] sq_cz [2];
  logic               sq_cull;
  logic               sq_clipped;

  // pixel dividers
  logic signed [48:0] dv_num [4];
  logic signed [52:0] dv_den [4];
  logic [48:0]        dv_un [4];
  logic [PIX_DW-1:0]  dv_ud [4];
  logic               dv_ovf [4];
  logic [PIX_DW-1:0]  dv_rem [4];
  logic [PIX_QW-1:0]  dv_n [4];
  logic [2:0]         dv_pay [4];
  logic               vis_ok;
  logic [3:0]         pd_valid;
  logic [PIX_QW-1:0]  pd_quo [4];
  logic [2:0]         pd_pay [4];

  // scaled pixel products
  logic [PIX_QW-1:0]  mag [4];
  logic signed [32:0] ndc [4];
  logic signed [33:0] ndc_diff [4];
  logic signed [16:0] size [4];
  logic               ss_valid;
  logic signed [50:0] ss_prod [4];
  logic               ss_vis;
  logic               ss_clipped;

  logic signed [50:0] adj [4];
  logic signed [33:0] shr [4];
  logic signed [15:0] pix [4];

  assign back_en  = !(ss_valid && out_full);
  assign q_pop    = back_en && !q_empty;
  assign out_push = ss_valid && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (back_en) begin
      sa_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sa_item <= q_data;
    end
  end

  // pick rear and front ends of a straddling segment
  always_comb begin
    cd_pay_in.cull    = sa_item.below0 && sa_item.below1;
    cd_pay_in.clipped = sa_item.below0 != sa_item.below1;
    if (cd_pay_in.clipped && sa_item.below1) begin
      cd_pay_in.a_pt = sa_item.p1;
      cd_pay_in.b_pt = sa_item.p0;
    end else begin
      cd_pay_in.a_pt = sa_item.p0;
      cd_pay_in.b_pt = sa_item.p1;
    end
    clip_a = 33'(ONE_Q16) - 33'(cd_pay_in.a_pt.z);
    clip_d = 33'(cd_pay_in.b_pt.z) - 33'(cd_pay_in.a_pt.z);
    // front end on the plane gives a full fraction of one
    cd_pay_in.front_on_plane = (clip_a == clip_d);
  end

  scp_div #(
    .DW(CLIP_DW),
    .QW(CLIP_QW),
    .PW($bits(clip_pay_t))
  ) u_clip_div (
    .clk      (clk),
    .rst      (rst),
    .en       (back_en),
    .in_valid (sa_valid),
    .in_rem   (clip_a),
    .in_den   (clip_d),
    .in_num   ('0),
    .in_pay   (cd_pay_in),
    .out_valid(cd_valid),
    .out_quo  (cd_t),
    .out_pay  (cd_pay)
  );

  always_comb begin
    dx = 33'(cd_pay.b_pt.x) - 33'(cd_pay.a_pt.x);
    dy = 33'(cd_pay.b_pt.y) - 33'(cd_pay.a_pt.y);
    th = signed'({1'b0, cd_t[CLIP_QW-1:CLIP_QW/2]});
    tl = signed'({1'b0, cd_t[CLIP_QW/2-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
      sn_valid <= 1'b0;
      sp_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else if (back_en) begin
      sm_valid <= cd_valid;
      sn_valid <= sm_valid;
      sp_valid <= sn_valid;
      sq_valid <= sp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sm_dxh <= dx * th;
      sm_dxl <= dx * tl;
      sm_dyh <= dy * th;
      sm_dyl <= dy * tl;
      sm_pay <= cd_pay;
    end
  end

  always_comb begin
    fx_full = (62'(sm_dxh) <<< (CLIP_QW / 2)) + 62'(sm_dxl);
    fy_full = (62'(sm_dyh) <<< (CLIP_QW / 2)) + 62'(sm_dyl);
    fx_sum  = (fx_full >>> CLIP_QW) + 62'(sm_pay.a_pt.x);
    fy_sum  = (fy_full >>> CLIP_QW) + 62'(sm_pay.a_pt.y);
    if (sm_pay.clipped) begin
      sn_next0.x = sm_pay.front_on_plane ? sm_pay.b_pt.x : fx_sum[31:0];
      sn_next0.y = sm_pay.front_on_plane ? sm_pay.b_pt.y : fy_sum[31:0];
      sn_next0.z = ONE_Q16;
    end else begin
      sn_next0 = sm_pay.a_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sn_pt[0]   <= sn_next0;
      sn_pt[1]   <= sm_pay.b_pt;
      sn_cull    <= sm_pay.cull;
      sn_clipped <= sm_pay.clipped;
      for (int k = 0; k < 2; k++) begin
        sp_mx[k]  <= sn_pt[k].x * cfg.p00;
        sp_mxz[k] <= sn_pt[k].z * cfg.p02;
        sp_my[k]  <= sn_pt[k].y * cfg.p11;
        sp_myz[k] <= sn_pt[k].z * cfg.p12;
        sp_mzz[k] <= sn_pt[k].z * cfg.p22;
      end
      sp_cull    <= sn_cull;
      sp_clipped <= sn_clipped;
      for (int k = 0; k < 2; k++) begin
        sq_cx[k] <= 49'(sp_mx[k]) + 49'(sp_mxz[k]);
        sq_cy[k] <= 49'(sp_my[k]) + 49'(sp_myz[k]);
        sq_cz[k] <= 53'(cz_sum[k] >>> 12);
      end
      sq_cull    <= sp_cull;
      sq_clipped <= sp_clipped;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cz_sum[k] = 65'(sp_mzz[k]) + (65'(cfg.p23) <<< 16);
    end
  end

  // coordinate order: start x, start y, end x, end y
  always_comb begin
    vis_ok = !sq_cull && (sq_cz[0] != '0) && (sq_cz[1] != '0);
    for (int c = 0; c < 4; c++) begin
      dv_num[c] = (c % 2 == 1) ? sq_cy[c / 2] : sq_cx[c / 2];
      dv_den[c] = sq_cz[c / 2];
      dv_un[c]  = dv_num[c][48] ? 49'(-dv_num[c]) : 49'(dv_num[c]);
      dv_ud[c]  = dv_den[c][52] ? PIX_DW'(-dv_den[c]) : PIX_DW'(dv_den[c]);
      dv_ovf[c] = PIX_DW'(dv_un[c][48:16]) >= dv_ud[c];
      dv_rem[c] = dv_ovf[c] ? '0 : PIX_DW'(dv_un[c][48:16]);
      dv_n[c]   = {dv_un[c][15:0], 16'h0000};
      dv_pay[c] = {dv_num[c][48] != dv_den[c][52], dv_ovf[c],
                   (c % 2 == 1) ? sq_clipped : vis_ok};
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_pix
    scp_div #(
      .DW(PIX_DW),
      .QW(PIX_QW),
      .PW(3)
    ) u_pix_div (
      .clk      (clk),
      .rst      (rst),
      .en       (back_en),
      .in_valid (sq_valid),
      .in_rem   (dv_rem[g]),
      .in_den   (dv_ud[g]),
      .in_num   (dv_n[g]),
      .in_pay   (dv_pay[g]),
      .out_valid(pd_valid[g]),
      .out_quo  (pd_quo[g]),
      .out_pay  (pd_pay[g])
    );
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (pd_pay[c][1] || (pd_quo[c] > 32'h8000_0000)) begin
        mag[c] = 32'h8000_0000;
      end else begin
        mag[c] = pd_quo[c];
      end
      ndc[c]      = pd_pay[c][2] ? -signed'({1'b0, mag[c]}) : signed'({1'b0, mag[c]});
      ndc_diff[c] = 34'(ONE_Q16) - 34'(ndc[c]);
      size[c]     = signed'({1'b0, (c % 2 == 1) ? cfg.img_h : cfg.img_w});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_valid <= 1'b0;
    end else if (back_en) begin
      ss_valid <= &pd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      for (int c = 0; c < 4; c++) begin
        ss_prod[c] <= 51'(ndc_diff[c]) * 51'(size[c]);
      end
      ss_vis     <= pd_pay[0][0] && pd_pay[2][0];
      ss_clipped <= pd_pay[1][0] && pd_pay[3][0];
    end
  end

  // halve toward zero, saturate to 16 bits; hidden segments give -1
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      adj[c] = ss_prod[c][50] ? ss_prod[c] + 51'sd131071 : ss_prod[c];
      shr[c] = 34'(adj[c] >>> 17);
      if (!ss_vis) begin
        pix[c] = -16'sd1;
      end else if (shr[c] > 34'sd32767) begin
        pix[c] = 16'sh7fff;
      end else if (shr[c] < -34'sd32768) begin
        pix[c] = 16'sh8000;
      end else begin
        pix[c] = shr[c][15:0];
      end
    end
    out_data.visible     = ss_vis;
    out_data.start_px    = pix[0];
    out_data.start_py    = pix[1];
    out_data.end_px      = pix[2];
    out_data.end_py      = pix[3];
    out_data.was_clipped = ss_clipped;
  end

endmodule

@@ tb/tb_segment_clip_project.sv @@
`timescale 1ns / 100ps

module tb_segment_clip_project;
  import scp_pkg::*;

  localparam longint Q16 = 65536;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROT0;
  logic [63:0] cfg_data = '0;
  segment_t seg_drv = '0;
  res_t seen;

  logic [63:0] shadow_reg [8];
  res_t expected_q [$];
  int mismatches = 0;
  int cycles = 0;
  bit push_idle_on = 1'b1;
  bit pop_idle_on = 1'b1;
  int pop_hold = 0;

  segment_clip_project u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .first_x(seg_drv.ax), .first_y(seg_drv.ay), .first_z(seg_drv.az),
    .second_x(seg_drv.bx), .second_y(seg_drv.by), .second_z(seg_drv.bz),
    .pop(pop), .empty(empty),
    .visible(seen.visible), .start_px(seen.start_px), .start_py(seen.start_py),
    .end_px(seen.end_px), .end_py(seen.end_py), .was_clipped(seen.was_clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[segment_clip_project] ERROR");
      $finish;
    end
  end

  function automatic longint sat_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rot_term(int row, int col);
    logic signed [15:0] t;
    t = shadow_reg[row][16*col +: 16];
    return longint'(t);
  endfunction

  function automatic longint camera_coord(int row, longint x, longint y, longint z);
    longint acc;
    logic signed [31:0] tr;
    acc = rot_term(row, 0) * x + rot_term(row, 1) * y + rot_term(row, 2) * z;
    case (row)
      0: tr = shadow_reg[REG_TRANS_XY][31:0];
      1: tr = shadow_reg[REG_TRANS_XY][63:32];
      default: tr = shadow_reg[REG_TRANS_Z][31:0];
    endcase
    return sat_range((acc >>> 14) + longint'(tr), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint pixel_of(longint num, longint den, longint size);
    longint unsigned un, ud, q;
    longint ndc, v;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un << 16) / ud;
    if (q > 64'd2147483648) q = 64'd2147483648;
    ndc = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    v = size * (Q16 - ndc) / (2 * Q16);
    return sat_range(v, -32768, 32767);
  endfunction

  function automatic bit project_point(longint x, longint y, longint z,
                                       output longint px, output longint py);
    logic signed [15:0] p00, p02, p11, p12;
    logic signed [31:0] p22, p23;
    longint cx, cy, cz;
    p00 = shadow_reg[REG_PROJ_XY][15:0];
    p02 = shadow_reg[REG_PROJ_XY][31:16];
    p11 = shadow_reg[REG_PROJ_XY][47:32];
    p12 = shadow_reg[REG_PROJ_XY][63:48];
    p22 = shadow_reg[REG_PROJ_Z][31:0];
    p23 = shadow_reg[REG_PROJ_Z][63:32];
    px = -1;
    py = -1;
    cx = longint'(p00) * x + longint'(p02) * z;
    cy = longint'(p11) * y + longint'(p12) * z;
    cz = (longint'(p22) * z + longint'(p23) * Q16) >>> 12;
    if (cz == 0) return 1'b0;
    px = pixel_of(cx, cz, longint'(shadow_reg[REG_IMAGE][15:0]));
    py = pixel_of(cy, cz, longint'(shadow_reg[REG_IMAGE][31:16]));
    return 1'b1;
  endfunction

  function automatic res_t project_segment(segment_t s);
    longint c0x, c0y, c0z, c1x, c1y, c1z;
    longint fx, fy, fz, bx, by, bz, t;
    longint sx, sy, sz, ex, ey, ez;
    longint x0, y0, x1, y1;
    bit below0, below1, vis;
    res_t r;
    c0x = camera_coord(0, s.ax, s.ay, s.az);
    c0y = camera_coord(1, s.ax, s.ay, s.az);
    c0z = camera_coord(2, s.ax, s.ay, s.az);
    c1x = camera_coord(0, s.bx, s.by, s.bz);
    c1y = camera_coord(1, s.bx, s.by, s.bz);
    c1z = camera_coord(2, s.bx, s.by, s.bz);
    below0 = c0z < Q16;
    below1 = c1z < Q16;
    x0 = -1; y0 = -1; x1 = -1; y1 = -1;
    vis = 1'b0;
    r.was_clipped = 1'b0;
    if (!(below0 && below1)) begin
      r.was_clipped = below0 != below1;
      if (r.was_clipped) begin
        if (below0) begin
          fx = c1x; fy = c1y; fz = c1z; bx = c0x; by = c0y; bz = c0z;
        end else begin
          fx = c0x; fy = c0y; fz = c0z; bx = c1x; by = c1y; bz = c1z;
        end
        t = ((Q16 - bz) << 28) / (fz - bz);
        sx = bx + (((fx - bx) * t) >>> 28);
        sy = by + (((fy - by) * t) >>> 28);
        sz = Q16;
        ex = fx; ey = fy; ez = fz;
      end else begin
        sx = c0x; sy = c0y; sz = c0z;
        ex = c1x; ey = c1y; ez = c1z;
      end
      vis = project_point(sx, sy, sz, x0, y0);
      if (vis) vis = project_point(ex, ey, ez, x1, y1);
      if (!vis) begin
        x0 = -1; y0 = -1; x1 = -1; y1 = -1;
      end
    end
    r.visible = vis;
    r.start_px = x0[15:0];
    r.start_py = y0[15:0];
    r.end_px = x1[15:0];
    r.end_py = y1[15:0];
    return r;
  endfunction

  // result checker and pop driver
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", seen);
      end else begin
        want = expected_q.pop_front();
        if (want.visible !== seen.visible || want.start_px !== seen.start_px ||
            want.start_py !== seen.start_py || want.end_px !== seen.end_px ||
            want.end_py !== seen.end_py || want.was_clipped !== seen.was_clipped) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p act %p", want, seen);
        end
      end
    end
    if (pop_idle_on && pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (pop_idle_on && $urandom_range(0, 99) < 30)
        pop_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TRANS_XY, REG_PROJ_XY, REG_PROJ_Z: shadow_reg[idx] = value;
      REG_TRANS_Z, REG_IMAGE: shadow_reg[idx] = {32'd0, value[31:0]};
      default: shadow_reg[idx] = {16'd0, value[47:0]};
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_segment(segment_t s);
    int r;
    push <= 1'b1;
    seg_drv <= s;
    do @(posedge clk); while (full);
    expected_q.insert(expected_q.size(), project_segment(s));
    if (push_idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 60) begin
        push <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int units);
    return units * 65536;
  endfunction

  function automatic segment_t make_segment(int a, int b, int c, int d, int e, int f);
    segment_t s;
    s = {32'(a), 32'(b), 32'(c), 32'(d), 32'(e), 32'(f)};
    return s;
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'h0001_0000;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      s.ax = $urandom_range(0, 60 * 65536) - 30 * 65536;
      s.ay = $urandom_range(0, 60 * 65536) - 30 * 65536;
      s.az = $urandom_range(0, 40 * 65536) - 8 * 65536;
      s.bx = $urandom_range(0, 60 * 65536) - 30 * 65536;
      s.by = $urandom_range(0, 60 * 65536) - 30 * 65536;
      s.bz = $urandom_range(0, 40 * 65536) - 8 * 65536;
    end else if (r < 90) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      s = {edge_value(), edge_value(), edge_value(), edge_value(), edge_value(), edge_value()};
    end
    return s;
  endfunction

  function automatic logic [15:0] rot_rand();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
  endfunction

  task automatic camera_setup(bit identity, bit wild);
    logic [15:0] one;
    one = 16'd16384;
    if (identity) begin
      write_reg(REG_ROT0, {32'd0, one});
      write_reg(REG_ROT1, {16'd0, one, 16'd0});
      write_reg(REG_ROT2, {one, 32'd0});
    end else begin
      write_reg(REG_ROT0, {rot_rand(), rot_rand(), one + rot_rand() / 4});
      write_reg(REG_ROT1, {rot_rand(), one + rot_rand() / 4, rot_rand()});
      write_reg(REG_ROT2, {one + rot_rand() / 4, rot_rand(), rot_rand()});
    end
    if (wild) begin
      write_reg(REG_TRANS_XY, {$urandom, $urandom});
      write_reg(REG_TRANS_Z, $urandom);
      write_reg(REG_PROJ_XY, {$urandom, $urandom});
      write_reg(REG_PROJ_Z, {$urandom, $urandom});
      write_reg(REG_IMAGE, $urandom);
    end else begin
      write_reg(REG_TRANS_XY, {32'($urandom_range(0, 20 * 65536) - 10 * 65536),
                               32'($urandom_range(0, 20 * 65536) - 10 * 65536)});
      write_reg(REG_TRANS_Z, $urandom_range(0, 10 * 65536));
      write_reg(REG_PROJ_XY, {16'($urandom_range(0, 1024) - 512), 16'($urandom_range(2048, 8192)),
                              16'($urandom_range(0, 1024) - 512), 16'($urandom_range(2048, 8192))});
      write_reg(REG_PROJ_Z, {32'(-$urandom_range(0, 1 << 24)),
                             32'((1 << 24) + $urandom_range(0, 1 << 22))});
      write_reg(REG_IMAGE, {16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))});
    end
  endtask

  task automatic test_reset_registers;
    send_segment(make_segment(q16(1), q16(2), q16(5), q16(-1), q16(-2), q16(8)));
    send_segment(make_segment(0, 0, 0, 0, 0, 0));
    send_segment(make_segment(q16(1), 0, q16(-3), 0, q16(1), q16(4)));
    drain();
  endtask

  task automatic test_directed_cases;
    camera_setup(1'b1, 1'b0);
    write_reg(REG_TRANS_XY, 64'd0);
    write_reg(REG_TRANS_Z, 64'd0);
    write_reg(REG_PROJ_XY, {16'd0, 16'd4096, 16'd0, 16'd4096});
    // p23 = -2.0 puts a zero divisor at camera z = 2.0
    write_reg(REG_PROJ_Z, {32'hfe00_0000, 32'h0100_0000});
    write_reg(REG_IMAGE, {16'd480, 16'd640});
    // both behind
    send_segment(make_segment(q16(1), q16(1), q16(-2), q16(3), q16(2), 32'h0000_ffff));
    // straddling, first behind then second behind
    send_segment(make_segment(q16(2), q16(-1), q16(-4), q16(-3), q16(2), q16(9)));
    send_segment(make_segment(q16(-3), q16(2), q16(9), q16(2), q16(-1), q16(-4)));
    // endpoint exactly on the plane
    send_segment(make_segment(q16(1), q16(1), q16(1), q16(2), q16(3), q16(6)));
    send_segment(make_segment(q16(1), q16(1), q16(1), q16(2), q16(3), q16(-6)));
    send_segment(make_segment(q16(1), q16(1), q16(1), q16(-2), q16(3), q16(1)));
    // zero divisor, plain and after clipping
    send_segment(make_segment(q16(1), q16(1), q16(2), q16(2), q16(3), q16(6)));
    send_segment(make_segment(q16(1), q16(1), q16(-1), q16(2), q16(3), q16(2)));
    // extremes of the fields
    send_segment({6{32'h7fff_ffff}});
    send_segment({6{32'h8000_0000}});
    send_segment({6{32'hffff_ffff}});
    send_segment(make_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_segment(make_segment(32'h7fff_ffff, 32'h8000_0000, q16(1),
                              32'h8000_0000, 32'h7fff_ffff, q16(3)));
    send_segment(make_segment(q16(1000), q16(-1000), 32'h0001_0001,
                              q16(-1000), q16(1000), q16(2) + 1));
    drain();
  endtask

  task automatic run_items(int count);
    for (int i = 0; i < count; i++) begin
      send_segment(random_segment());
      if (i == count / 2) drain();
    end
    drain();
  endtask

  task automatic test_extreme_registers;
    for (int idx = 0; idx < 8; idx++) write_reg(idx[CFG_IDX_W-1:0], '1);
    run_items(80);
    for (int idx = 0; idx < 8; idx++) write_reg(idx[CFG_IDX_W-1:0], '0);
    run_items(40);
    write_reg(REG_ROT0, {32'd0, 16'h8000});
    write_reg(REG_ROT1, {16'd0, 16'h7fff, 16'd0});
    write_reg(REG_ROT2, {16'h7fff, 32'd0});
    write_reg(REG_TRANS_XY, {32'h7fff_ffff, 32'h8000_0000});
    write_reg(REG_TRANS_Z, 32'h7fff_ffff);
    write_reg(REG_PROJ_XY, {16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    write_reg(REG_PROJ_Z, {32'h8000_0000, 32'h7fff_ffff});
    write_reg(REG_IMAGE, 32'hffff_ffff);
    run_items(80);
  endtask

  task automatic test_random_cameras;
    for (int phase = 0; phase < 9; phase++) begin
      push_idle_on = (phase != 3);
      pop_idle_on = (phase != 3) && (phase != 5);
      camera_setup(phase == 0, phase == 7);
      run_items(200);
    end
    push_idle_on = 1'b1;
    pop_idle_on = 1'b1;
  endtask

  initial begin
    shadow_reg[REG_ROT0] = 64'(ROT_ONE);
    shadow_reg[REG_ROT1] = 64'(ROT_ONE) << 16;
    shadow_reg[REG_ROT2] = 64'(ROT_ONE) << 32;
    for (int idx = 3; idx < 8; idx++) shadow_reg[idx] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_registers();
    test_directed_cases();
    test_extreme_registers();
    test_random_cameras();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[segment_clip_project] OK");
    end else begin
      $display("[segment_clip_project] ERROR");
    end
    $finish;
  end

endmodule
